// ===== sv/cprm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprm_pkg: shared types and constants for the position-to-read mapper
// Controller states, item codes and default sizes.
// ----------------------------------------------------------------------------
package cprm_pkg;

    localparam int DEF_MAX_READS = 65536;
    localparam int DEF_LEN_BITS  = 16;

    localparam logic [15:0] MIN_SUFFIX_RST = 16'd30;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MAP  = 1'b1;

    localparam logic TISSUE_HEALTHY = 1'b1;
    localparam logic TISSUE_TUMOUR  = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK
    } t_state;

endpackage
`default_nettype wire

// ===== sv/concat_position_to_read_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// concat_position_to_read_mapper: joint concatenation position to read id
// A load beat appends one read length to the healthy or tumour set. A map
// beat binary-searches the read starts of the set that holds the position and returns id and offset.
// ----------------------------------------------------------------------------
// Load: the controller stays in idle, so the next beat is taken in the following cycle.
// Map: an accept in idle, then search steps in ST_SEARCH, one RAM read each, until the
//   search range is empty, then a check in ST_CHECK.
// A map past the end or into an empty set drops in its accept cycle.
// The check state holds while the previous result waits in the output register and the new result is kept.
// Reset clears counts and totals and sets the minimum suffix length to 30; no RAM clear.
module concat_position_to_read_mapper #(
    parameter int MAX_READS = cprm_pkg::DEF_MAX_READS,
    parameter int LEN_BITS  = cprm_pkg::DEF_LEN_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic        i_tissue,
    input  wire logic [15:0] i_read_len,
    input  wire logic [31:0] i_position,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [15:0] o_read_id,
    output logic      [15:0] o_suffix_offset,
    output logic             o_tissue_out,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_READS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SLEN_W = (LEN_BITS < 16) ? LEN_BITS : 16;
    localparam int DW     = 32 + SLEN_W;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_READS);

    // control state
    cprm_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_hcnt, r_tcnt;
    logic [31:0]        r_htot, r_ttot;
    logic [15:0]        r_min;
    logic               r_ovalid, n_ovalid;
    logic               r_found, n_found;

    // search datapath
    logic [CNT_W-1:0]   r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic [31:0]        r_q, n_q;
    logic               r_set, n_set;
    logic [IDX_W-1:0]   r_cidx, n_cidx;
    logic [31:0]        r_cstart, n_cstart;
    logic [SLEN_W-1:0]  r_clen, n_clen;

    // result register
    logic [15:0]        r_oid, r_ooff;
    logic               r_otis;

    // RAM
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [DW-1:0]      w_wdata, w_rdata;
    logic [31:0]        w_rd_start;
    logic [SLEN_W-1:0]  w_rd_len;

    // accept side
    logic               w_acc;
    logic               w_load, w_map;
    logic [SLEN_W-1:0]  w_len_in;
    logic               w_in_set;
    logic [31:0]        w_in_q;
    logic [CNT_W-1:0]   w_in_cnt;
    logic               w_in_drop;
    logic               w_ld_full;
    logic [CNT_W-1:0]   w_ld_cnt;

    // search step
    logic               w_le;
    logic [CNT_W-1:0]   w_lo_s, w_hi_s, w_mid_s;
    logic               w_more;

    // check
    logic [31:0]        w_off, w_len32, w_rem;
    logic               w_keep, w_out_free;
    logic [31:0]        w_id32;

    cprm_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_start = w_rdata[DW-1:SLEN_W];
    assign w_rd_len   = w_rdata[SLEN_W-1:0];

    assign o_ready     = (r_state == cprm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && o_ready;
    assign w_load      = w_acc && (i_func == cprm_pkg::FUNC_LOAD);
    assign w_map       = w_acc && (i_func == cprm_pkg::FUNC_MAP);
    assign w_len_in    = i_read_len[SLEN_W-1:0];

    // pick the set: healthy positions come first in the joint string
    always_comb begin
        if (i_position < r_htot) begin
            w_in_set  = cprm_pkg::TISSUE_HEALTHY;
            w_in_q    = i_position;
            w_in_cnt  = r_hcnt;
            w_in_drop = (r_hcnt == '0);
        end else begin
            w_in_set  = cprm_pkg::TISSUE_TUMOUR;
            w_in_q    = i_position - r_htot;
            w_in_cnt  = r_tcnt;
            w_in_drop = (w_in_q >= r_ttot) || (r_tcnt == '0);
        end
    end

    assign w_ld_cnt  = (i_tissue == cprm_pkg::TISSUE_HEALTHY) ? r_hcnt : r_tcnt;
    assign w_ld_full = (w_ld_cnt == FULL_CNT);

    assign w_we    = w_load && !w_ld_full;
    assign w_waddr = {i_tissue, w_ld_cnt[IDX_W-1:0]};
    assign w_wdata = {((i_tissue == cprm_pkg::TISSUE_HEALTHY) ? r_htot : r_ttot), w_len_in};

    // one search step: the start at r_mid is on the RAM output now
    assign w_le    = (w_rd_start <= r_q);
    assign w_lo_s  = w_le ? (CNT_W'(r_mid) + CNT_W'(1)) : r_lo;
    assign w_hi_s  = w_le ? r_hi : CNT_W'(r_mid);
    assign w_more  = (w_lo_s < w_hi_s);
    assign w_mid_s = w_lo_s + ((w_hi_s - w_lo_s) >> 1);

    // final check on the last start at or below the position
    assign w_off      = r_q - r_cstart;
    assign w_len32    = 32'(r_clen);
    assign w_rem      = w_len32 - w_off;
    assign w_keep     = r_found && (w_off < w_len32) && (w_rem > 32'(r_min));
    assign w_out_free = !r_ovalid || i_ready;
    assign w_id32     = 32'(r_cidx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cprm_pkg::ST_IDLE: begin
                if (w_map && !w_in_drop) begin
                    n_state = cprm_pkg::ST_SEARCH;
                end
            end
            cprm_pkg::ST_SEARCH: begin
                if (!w_more) begin
                    n_state = cprm_pkg::ST_CHECK;
                end
            end
            cprm_pkg::ST_CHECK: begin
                if (!w_keep || w_out_free) begin
                    n_state = cprm_pkg::ST_IDLE;
                end
            end
            default: n_state = cprm_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM read address
    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_q      = r_q;
        n_set    = r_set;
        n_found  = r_found;
        n_cidx   = r_cidx;
        n_cstart = r_cstart;
        n_clen   = r_clen;
        w_raddr  = {r_set, r_mid};
        n_ovalid = r_ovalid && !i_ready;
        case (r_state)
            cprm_pkg::ST_IDLE: begin
                w_raddr = {w_in_set, w_in_cnt[IDX_W:1]};
                if (w_map) begin
                    n_lo    = '0;
                    n_hi    = w_in_cnt;
                    n_mid   = w_in_cnt[IDX_W:1];
                    n_q     = w_in_q;
                    n_set   = w_in_set;
                    n_found = 1'b0;
                end
            end
            cprm_pkg::ST_SEARCH: begin
                n_lo    = w_lo_s;
                n_hi    = w_hi_s;
                n_mid   = w_mid_s[IDX_W-1:0];
                w_raddr = {r_set, w_mid_s[IDX_W-1:0]};
                // hold the latest start at or below the position
                if (w_le) begin
                    n_found  = 1'b1;
                    n_cidx   = r_mid;
                    n_cstart = w_rd_start;
                    n_clen   = w_rd_len;
                end
            end
            cprm_pkg::ST_CHECK: begin
                if (w_keep && w_out_free) begin
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cprm_pkg::ST_IDLE;
            r_hcnt   <= '0;
            r_tcnt   <= '0;
            r_htot   <= '0;
            r_ttot   <= '0;
            r_min    <= cprm_pkg::MIN_SUFFIX_RST;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            if (w_we) begin
                if (i_tissue == cprm_pkg::TISSUE_HEALTHY) begin
                    r_hcnt <= r_hcnt + CNT_W'(1);
                    r_htot <= r_htot + 32'(w_len_in);
                end else begin
                    r_tcnt <= r_tcnt + CNT_W'(1);
                    r_ttot <= r_ttot + 32'(w_len_in);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_q      <= n_q;
        r_set    <= n_set;
        r_cidx   <= n_cidx;
        r_cstart <= n_cstart;
        r_clen   <= n_clen;
        if (r_state == cprm_pkg::ST_CHECK && w_keep && w_out_free) begin
            r_oid  <= w_id32[15:0];
            r_ooff <= w_off[15:0];
            r_otis <= r_set;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_read_id       = r_oid;
    assign o_suffix_offset = r_ooff;
    assign o_tissue_out    = r_otis;

endmodule
`default_nettype wire

// ===== sv/cprm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cprm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cprm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
